// ===== rtl/tse_pkg.sv =====
// Shared types and constants of the TLS server name extractor.
package tse_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 16;
   localparam int unsigned ACC_W               = 16;

   localparam logic [7:0]  RECORD_HANDSHAKE  = 8'h16;
   localparam logic [7:0]  VERSION_MAJOR     = 8'h03;
   localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
   localparam logic [15:0] EXT_SERVER_NAME   = 16'h0000;
   localparam logic [7:0]  PRINTABLE_LO      = 8'h20;
   localparam logic [7:0]  PRINTABLE_HI      = 8'h7E;

   localparam int unsigned POS_RECORD_TYPE   = 0;
   localparam int unsigned POS_VERSION_MAJOR = 1;
   localparam int unsigned POS_HS_TYPE       = 5;
   localparam int unsigned HEADER_LAST       = 42;
   localparam int unsigned MIN_LENGTH        = 43;
   localparam int unsigned FIELD_BYTES       = 2;
   localparam int unsigned EXT_HDR_BYTES     = 4;
   localparam int unsigned SNI_HDR_BYTES     = 5;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] payload_length;
      logic        first_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] name_char;
      logic       char_printable;
      logic       name_done;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ===== rtl/tse_parser.sv =====
// Byte-serial ClientHello walker that produces at most one server name byte per accepted transaction.
module tse_parser #(
   parameter int unsigned LENGTH_BITS = tse_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tse_pkg::req_type    req,
   output tse_pkg::result_type result
);
   import tse_pkg::*;

   localparam int unsigned LW   = LENGTH_BITS;
   localparam int unsigned SW   = ACC_W + 2;
   localparam int unsigned EE_W = ACC_W + 1;

   typedef enum logic [14:0] {
      PH_IDLE     = 15'h0001,
      PH_HEADER   = 15'h0002,
      PH_SID_LEN  = 15'h0004,
      PH_SID_SKIP = 15'h0008,
      PH_CS_LEN   = 15'h0010,
      PH_CS_SKIP  = 15'h0020,
      PH_CM_LEN   = 15'h0040,
      PH_CM_SKIP  = 15'h0080,
      PH_EXT_LEN  = 15'h0100,
      PH_EXT_TYPE = 15'h0200,
      PH_SIZE_OTH = 15'h0400,
      PH_SIZE_SNI = 15'h0800,
      PH_EXT_SKIP = 15'h1000,
      PH_SNI_HDR  = 15'h2000,
      PH_NAME     = 15'h4000
   } phase_type;

   phase_type           phase_ff, phase_in, phase_cur;
   logic [LW-1:0]       pos_ff, pos_in, pos_cur;
   logic [LW-1:0]       len_ff, len_in, len_cur;
   logic [ACC_W-1:0]    acc_ff, acc_in, acc_sh;
   logic [ACC_W-1:0]    skip_ff, skip_in, skip_dec;
   logic [EE_W-1:0]     ext_end_ff, ext_end_in;
   logic [ACC_W-1:0]    name_rem_ff, name_rem_in;
   logic [7:0]          b;
   logic                skip_last;
   logic [SW-1:0]       p1, len_ext, end_ext, b_ext, acc_ext;
   logic [SW-1:0]       sum_b, sum_acc, new_end;

   assign b         = req.data_byte;
   assign acc_sh    = {acc_ff[7:0], b};
   assign skip_dec  = skip_ff - 1'b1;
   assign skip_last = (skip_ff == ACC_W'(1));

   always_comb begin
      len_cur   = len_ff;
      pos_cur   = pos_ff;
      phase_cur = phase_ff;
      if (req.first_byte) begin
         len_cur   = req.payload_length[LW-1:0];
         pos_cur   = '0;
         phase_cur = (len_cur < LW'(MIN_LENGTH)) ? PH_IDLE : PH_HEADER;
      end
   end

   assign p1      = SW'(pos_cur) + SW'(1);
   assign len_ext = SW'(len_cur);
   assign end_ext = SW'(ext_end_ff);
   assign b_ext   = SW'(b);
   assign acc_ext = SW'(acc_sh);
   assign sum_b   = p1 + b_ext;
   assign sum_acc = p1 + acc_ext;
   assign new_end = SW'(sum_acc[EE_W-1:0]);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      skip_in     = skip_ff;
      ext_end_in  = ext_end_ff;
      name_rem_in = name_rem_ff;
      result.valid               = 1'b0;
      result.data.name_char      = b;
      result.data.char_printable = (b >= PRINTABLE_LO) && (b <= PRINTABLE_HI);
      result.data.name_done      = (name_rem_ff == ACC_W'(1));
      if (accept) begin
         len_in   = len_cur;
         pos_in   = pos_cur;
         phase_in = phase_cur;
         if (phase_cur != PH_IDLE && pos_cur >= len_cur) begin
            phase_in = PH_IDLE;
         end else if (phase_cur != PH_IDLE) begin
            pos_in = pos_cur + 1'b1;
            acc_in = acc_sh;
            case (phase_cur)
               PH_HEADER: begin
                  if ((pos_cur == LW'(POS_RECORD_TYPE) && b != RECORD_HANDSHAKE) ||
                      (pos_cur == LW'(POS_VERSION_MAJOR) && b != VERSION_MAJOR) ||
                      (pos_cur == LW'(POS_HS_TYPE) && b != HS_CLIENT_HELLO)) begin
                     phase_in = PH_IDLE;
                  end else if (pos_cur == LW'(HEADER_LAST)) begin
                     phase_in = PH_SID_LEN;
                  end
               end
               PH_SID_LEN, PH_CM_LEN: begin
                  if (sum_b + SW'(FIELD_BYTES) > len_ext) begin
                     phase_in = PH_IDLE;
                  end else if (b == 8'h00) begin
                     phase_in = (phase_cur == PH_SID_LEN) ? PH_CS_LEN : PH_EXT_LEN;
                     skip_in  = ACC_W'(FIELD_BYTES);
                     acc_in   = '0;
                  end else begin
                     phase_in = (phase_cur == PH_SID_LEN) ? PH_SID_SKIP : PH_CM_SKIP;
                     skip_in  = ACC_W'(b);
                  end
               end
               PH_CS_LEN: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     if (sum_acc + SW'(1) > len_ext) begin
                        phase_in = PH_IDLE;
                     end else if (acc_sh == '0) begin
                        phase_in = PH_CM_LEN;
                     end else begin
                        phase_in = PH_CS_SKIP;
                        skip_in  = acc_sh;
                     end
                  end
               end
               PH_SID_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     phase_in = PH_CS_LEN;
                     skip_in  = ACC_W'(FIELD_BYTES);
                     acc_in   = '0;
                  end
               end
               PH_CS_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     phase_in = PH_CM_LEN;
                  end
               end
               PH_CM_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     phase_in = PH_EXT_LEN;
                     skip_in  = ACC_W'(FIELD_BYTES);
                     acc_in   = '0;
                  end
               end
               PH_EXT_LEN: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     ext_end_in = new_end[EE_W-1:0];
                     if (new_end > len_ext) begin
                        phase_in = PH_IDLE;
                     end else if (p1 + SW'(EXT_HDR_BYTES) <= new_end) begin
                        phase_in = PH_EXT_TYPE;
                        skip_in  = ACC_W'(FIELD_BYTES);
                        acc_in   = '0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_EXT_TYPE: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     phase_in = (acc_sh == EXT_SERVER_NAME) ? PH_SIZE_SNI : PH_SIZE_OTH;
                     skip_in  = ACC_W'(FIELD_BYTES);
                     acc_in   = '0;
                  end
               end
               PH_SIZE_OTH, PH_SIZE_SNI: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     if (sum_acc > end_ext) begin
                        phase_in = PH_IDLE;
                     end else if (phase_cur == PH_SIZE_SNI) begin
                        if (p1 + SW'(SNI_HDR_BYTES) > end_ext) begin
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_SNI_HDR;
                           skip_in  = ACC_W'(SNI_HDR_BYTES);
                           acc_in   = '0;
                        end
                     end else if (acc_sh == '0) begin
                        if (p1 + SW'(EXT_HDR_BYTES) <= end_ext) begin
                           phase_in = PH_EXT_TYPE;
                           skip_in  = ACC_W'(FIELD_BYTES);
                           acc_in   = '0;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        phase_in = PH_EXT_SKIP;
                        skip_in  = acc_sh;
                     end
                  end
               end
               PH_EXT_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     if (p1 + SW'(EXT_HDR_BYTES) <= end_ext) begin
                        phase_in = PH_EXT_TYPE;
                        skip_in  = ACC_W'(FIELD_BYTES);
                        acc_in   = '0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_SNI_HDR: begin
                  skip_in = skip_dec;
                  if (skip_last) begin
                     if (sum_acc > end_ext || acc_sh == '0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in    = PH_NAME;
                        name_rem_in = acc_sh;
                     end
                  end
               end
               PH_NAME: begin
                  result.valid = 1'b1;
                  name_rem_in  = name_rem_ff - 1'b1;
                  if (name_rem_ff == ACC_W'(1)) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         if (req.last_byte) begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         pos_ff      <= '0;
         len_ff      <= '0;
         acc_ff      <= '0;
         skip_ff     <= '0;
         ext_end_ff  <= '0;
         name_rem_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         acc_ff      <= acc_in;
         skip_ff     <= skip_in;
         ext_end_ff  <= ext_end_in;
         name_rem_ff <= name_rem_in;
      end
   end

endmodule

// ===== rtl/tse_out_buf.sv =====
// Two-entry output register with skid stage for the result channel.
module tse_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  tse_pkg::result_type result,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tse_pkg::rsp_type    rsp_data
);
   import tse_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result.data;
            main_valid_in = result.valid;
         end
      end else if (result.valid) begin
         skid_in       = result.data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/tls_sni_extractor.sv =====
// Top level of the TLS server name extractor.
// Output: an accepted name byte is registered, in the skid entry while rsp stalls.
// Throughput: one payload byte per cycle; req_ready falls only while both output
// registers hold a result, set by the two-entry output register.
// Reset: synchronous, active high; parse state goes idle and output valids clear.
module tls_sni_extractor #(
   parameter int unsigned LENGTH_BITS = tse_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tse_pkg::rsp_type rsp_data
);
   import tse_pkg::*;

   result_type result;
   logic       accept;

   assign accept = req_valid && req_ready;

   tse_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .result (result)
   );

   tse_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
